// ----- src/bpt_pkg.sv -----
package bpt_pkg;

	// Fixed-point word used for coordinates, matrix entries and centroids
	localparam int FIX_W = 32;
	typedef logic signed [FIX_W-1:0] fix_t;

	// Exact product and exact sum of three products
	typedef logic signed [2*FIX_W-1:0] prod_t;
	typedef logic signed [2*FIX_W+1:0] acc_t;

	// Item kinds carried in tuser
	localparam logic [2:0] OP_LOAD_ROW = 3'd0;
	localparam logic [2:0] OP_FWD_PT   = 3'd1;
	localparam logic [2:0] OP_FWD_DIR  = 3'd2;
	localparam logic [2:0] OP_INV_PT   = 3'd3;
	localparam logic [2:0] OP_INV_DIR  = 3'd4;

	// Configuration register indexes
	localparam logic [2:0] REG_OLD_X = 3'd0;
	localparam logic [2:0] REG_OLD_Y = 3'd1;
	localparam logic [2:0] REG_OLD_Z = 3'd2;
	localparam logic [2:0] REG_NEW_X = 3'd3;
	localparam logic [2:0] REG_NEW_Y = 3'd4;
	localparam logic [2:0] REG_NEW_Z = 3'd5;

	// Number of matrix rows selectable by a load item
	localparam logic [1:0] ROW_COUNT = 2'd3;

endpackage

// ----- src/basis_point_transform.sv -----
// Channel   Direction  Width            Contents
// s_axis    in         tdata 96, tuser 5 point, direction or matrix row
// m_axis    out        tdata 96         transformed vector
// cfg       in         index 3, data 32 old and new centroids
//
// One item is accepted per cycle while the input is ready; a transform result reaches the output
// through the input, product, sum and result registers.
// The nine products of a transform are formed in parallel in one stage.
// Load items and unused kinds leave no result and take one slot at the input.
// Reset puts the identity in the basis matrix and clears both centroids.
// A stalled result holds every full stage behind it; bubbles still move up.
module basis_point_transform
	import bpt_pkg::*;
#(
	parameter int FRAC_BITS = 16
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [95:0] s_axis_tdata,  // coord_x, coord_y, coord_z
	input  logic [4:0]  s_axis_tuser,  // opcode, row_select
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [95:0] m_axis_tdata,  // out_x, out_y, out_z
	input  logic        cfg_we,
	input  logic [2:0]  cfg_index,
	input  logic [31:0] cfg_data
);

	localparam fix_t FIX_ONE = fix_t'(32'sd1 <<< FRAC_BITS);

	function automatic fix_t sat33(input logic signed [FIX_W:0] x);
		logic signed [FIX_W:0] hi;
		logic signed [FIX_W:0] lo;
		hi = (FIX_W+1)'($signed({1'b0, {(FIX_W-1){1'b1}}}));
		lo = -hi - (FIX_W+1)'(1);
		if (x > hi) begin
			return fix_t'(hi);
		end else if (x < lo) begin
			return fix_t'(lo);
		end
		return x[FIX_W-1:0];
	endfunction

	function automatic fix_t sat_acc(input acc_t x);
		acc_t hi;
		acc_t lo;
		hi = acc_t'($signed({1'b0, {(FIX_W-1){1'b1}}}));
		lo = -hi - acc_t'(1);
		if (x > hi) begin
			return fix_t'(hi);
		end else if (x < lo) begin
			return fix_t'(lo);
		end
		return x[FIX_W-1:0];
	endfunction

	logic [2:0] in_op;
	logic [1:0] in_row;
	fix_t       in_v [3];
	logic       accept;
	logic       is_xform;

	fix_t old_q [3];
	fix_t new_q [3];
	fix_t mat_q [9];

	logic       v_s1, v_s2, v_s3;
	logic [2:0] op_s1, op_s2, op_s3;
	fix_t       w_s1 [3];
	prod_t      prod_s2 [9];
	acc_t       sum_s3 [3];
	logic       en1, en2, en3, en_out;

	logic       out_v_q;
	fix_t       out_q [3];

	fix_t       w_d [3];
	fix_t       a_d [9];
	fix_t       res_d [3];

	assign in_op  = s_axis_tuser[2:0];
	assign in_row = s_axis_tuser[4:3];
	assign in_v[0] = $signed(s_axis_tdata[31:0]);
	assign in_v[1] = $signed(s_axis_tdata[63:32]);
	assign in_v[2] = $signed(s_axis_tdata[95:64]);

	// Advance each stage when the one ahead is empty or moving
	assign en_out = !out_v_q || m_axis_tready;
	assign en3    = !v_s3 || en_out;
	assign en2    = !v_s2 || en3;
	assign en1    = !v_s1 || en2;

	assign s_axis_tready = en1;
	assign accept        = s_axis_tvalid && en1;
	assign is_xform      = (in_op == OP_FWD_PT) || (in_op == OP_FWD_DIR) ||
	                       (in_op == OP_INV_PT) || (in_op == OP_INV_DIR);

	// Centroid registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 3; k++) begin
				old_q[k] <= '0;
				new_q[k] <= '0;
			end
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_OLD_X: old_q[0] <= $signed(cfg_data);
				REG_OLD_Y: old_q[1] <= $signed(cfg_data);
				REG_OLD_Z: old_q[2] <= $signed(cfg_data);
				REG_NEW_X: new_q[0] <= $signed(cfg_data);
				REG_NEW_Y: new_q[1] <= $signed(cfg_data);
				REG_NEW_Z: new_q[2] <= $signed(cfg_data);
				default: ;
			endcase
		end
	end

	// Basis matrix, row-major; load one row per item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < 9; k++) begin
				mat_q[k] <= (k == 0 || k == 4 || k == 8) ? FIX_ONE : '0;
			end
		end else if (accept && in_op == OP_LOAD_ROW && in_row < ROW_COUNT) begin
			for (int j = 0; j < 3; j++) begin
				mat_q[3*in_row + j] <= in_v[j];
			end
		end
	end

	// Subtract the old centroid for a forward point
	always_comb begin
		for (int k = 0; k < 3; k++) begin
			if (in_op == OP_FWD_PT) begin
				w_d[k] = sat33((FIX_W+1)'(in_v[k]) - (FIX_W+1)'(old_q[k]));
			end else begin
				w_d[k] = in_v[k];
			end
		end
	end

	// Stage 1: input register, transforms only
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
		end else if (en1) begin
			v_s1 <= accept && is_xform;
		end
	end

	always_ff @(posedge clk) begin
		if (en1) begin
			op_s1 <= in_op;
			w_s1  <= w_d;
		end
	end

	// Pick the matrix or its transpose
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			for (int j = 0; j < 3; j++) begin
				if (op_s1 == OP_INV_PT || op_s1 == OP_INV_DIR) begin
					a_d[3*i + j] = mat_q[3*j + i];
				end else begin
					a_d[3*i + j] = mat_q[3*i + j];
				end
			end
		end
	end

	// Stage 2: nine exact products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
		end else if (en2) begin
			v_s2 <= v_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (en2) begin
			op_s2 <= op_s1;
			for (int i = 0; i < 3; i++) begin
				for (int j = 0; j < 3; j++) begin
					prod_s2[3*i + j] <= prod_t'(a_d[3*i + j]) * prod_t'(w_s1[j]);
				end
			end
		end
	end

	// Stage 3: exact sum of each row's products
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
		end else if (en3) begin
			v_s3 <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (en3) begin
			op_s3 <= op_s2;
			for (int i = 0; i < 3; i++) begin
				sum_s3[i] <= acc_t'(prod_s2[3*i]) + acc_t'(prod_s2[3*i + 1]) +
				             acc_t'(prod_s2[3*i + 2]);
			end
		end
	end

	// Floor shift, saturate, then add the new centroid for an inverse point
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			res_d[i] = sat_acc(sum_s3[i] >>> FRAC_BITS);
			if (op_s3 == OP_INV_PT) begin
				res_d[i] = sat33((FIX_W+1)'(res_d[i]) + (FIX_W+1)'(new_q[i]));
			end
		end
	end

	// Result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (en_out) begin
			out_v_q <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (en_out && v_s3) begin
			out_q <= res_d;
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = {out_q[2], out_q[1], out_q[0]};

endmodule

// ----- src/bpt_checker.sv -----
module bpt_checker
	import bpt_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	input logic        s_axis_tvalid,
	input logic        s_axis_tready,
	input logic [4:0]  s_axis_tuser,
	input logic        m_axis_tvalid,
	input logic        m_axis_tready,
	input logic [95:0] m_axis_tdata,
	input logic        cfg_we,
	input logic [2:0]  cfg_index
);

	logic acc_xform;

	assign acc_xform = s_axis_tvalid && s_axis_tready &&
	                   (s_axis_tuser[2:0] == OP_FWD_PT || s_axis_tuser[2:0] == OP_FWD_DIR ||
	                    s_axis_tuser[2:0] == OP_INV_PT || s_axis_tuser[2:0] == OP_INV_DIR);

	// An empty or draining result register never holds back the input
	a_ready_free: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_axis_tvalid || m_axis_tready) |-> s_axis_tready)
		else $error("input stalled with the result side free");

	// A transform reaches the output when the output side does not stall
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		acc_xform ##1 m_axis_tready ##1 m_axis_tready ##1 m_axis_tready |=> m_axis_tvalid)
		else $error("transform item lost in the pipeline");

	// Hold a pending result until taken
	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> m_axis_tvalid)
		else $error("result dropped before it was taken");

	a_data_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && !m_axis_tready) |=> $stable(m_axis_tdata))
		else $error("result changed while stalled");

	// Config port must not be idle-unknown
	a_cfg_known: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |-> !$isunknown(cfg_index))
		else $error("configuration write with unknown index");

endmodule

bind basis_point_transform bpt_checker u_bpt_checker (.*);
